/* rtl/pprt_pkg.sv */
// Shared types and constants for the pending prefix route table.
package pprt_pkg;

  localparam int unsigned DefTableDepth = 64;
  localparam logic [5:0]  DefResultLimit = 6'd16;
  localparam logic [31:0] FullMask = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_ADD_GW  = 2'd0,
    OP_ADD_DIR = 2'd1,
    OP_DELETE  = 2'd2,
    OP_LOOKUP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_MATCH    = 3'd3,
    ST_NOMATCH  = 3'd4,
    ST_LISTFULL = 3'd5,
    ST_TABFULL  = 3'd6
  } status_t;

  typedef struct packed {
    logic [31:0] key_addr;
    logic [31:0] key_mask;
    logic [31:0] route_dest;
    logic [31:0] route_mask;
    logic        gateway;
  } entry_t;

endpackage

/* rtl/pprt_mem.sv */
// Entry memory: one write port, one registered read port.
module pprt_mem
  import pprt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/pending_prefix_route_table.sv */
// Pending prefix route table: a sorted table of next-hop entries held in one memory, scanned
// in order by a sequencer. A request is accepted only while the sequencer is idle, and each
// slot visited is read and then evaluated: an add or delete scans to its position and then
// moves each later entry by one slot (read, then write back); a lookup stops at the first key
// above the neighbour and emits the matches it finds, up to the result limit. A result waiting
// at the output holds the scan until it is taken. Results leave through an output register,
// and no clearing pass is needed after reset because only slots below the entry count are used.
module pending_prefix_route_table
  import pprt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_gateway_addr,
  input  logic [31:0] in_route_addr,
  input  logic [31:0] in_route_mask,
  input  logic [31:0] in_neighbor_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_match_addr,
  output logic [31:0] out_match_mask,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_result_limit
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_SHRD  = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  limit_r;
  op_t         op_r;
  logic [31:0] nkey_r, naddr_r;
  entry_t      new_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic [6:0]  nmatch_r, nmatch_nxt;
  entry_t      hold_r, hold_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [31:0] oaddr_r, oaddr_nxt, omask_r, omask_nxt;
  logic        olast_r, olast_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;
  logic [31:0]   mk;
  logic          in_acc, out_free;

  pprt_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE) && !ov_r;
  assign out_free  = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_match_addr = oaddr_r;
  assign out_match_mask = omask_r;
  assign out_last = olast_r;
  assign mk = rd_data.key_addr & rd_data.key_mask;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt = pos_r;
    sh_nxt = sh_r;
    nmatch_nxt = nmatch_r;
    hold_nxt = hold_r;
    ov_nxt = ov_r && out_stall;
    ost_nxt = ost_r;
    oaddr_nxt = oaddr_r;
    omask_nxt = omask_r;
    olast_nxt = olast_r;
    wr_en = 1'b0;
    wr_addr = pos_r[AW-1:0];
    wr_data = new_r;
    rd_addr = pos_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        pos_nxt = '0;
        nmatch_nxt = '0;
        if (in_acc) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (pos_r >= count_r) begin
          state_nxt = S_DONE;
          olast_nxt = 1'b1;
          oaddr_nxt = '0;
          omask_nxt = '0;
          unique case (op_r)
            OP_DELETE: ost_nxt = ST_NOTFOUND;
            OP_LOOKUP: ost_nxt = (nmatch_r == '0) ? ST_NOMATCH : ST_MATCH;
            default: begin
              if (count_r >= CW'(TABLE_DEPTH)) begin
                ost_nxt = ST_TABFULL;
              end else begin
                ost_nxt = ST_OK;
                wr_en = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
          endcase
          if (op_r == OP_LOOKUP && nmatch_r != '0) begin
            state_nxt = S_EMIT;
            oaddr_nxt = hold_r.key_addr;
            omask_nxt = hold_r.key_mask;
          end
        end else begin
          unique case (op_r)
            OP_LOOKUP: begin
              if (mk > naddr_r) begin
                pos_nxt = count_r;
              end else if ((naddr_r & rd_data.key_mask) == mk) begin
                if (nmatch_r >= {1'b0, limit_r}) begin
                  state_nxt = S_EMIT;
                  if (nmatch_r == '0 || nmatch_r > {1'b0, limit_r}) begin
                    ost_nxt = ST_LISTFULL;
                    oaddr_nxt = '0;
                    omask_nxt = '0;
                    olast_nxt = 1'b1;
                    pos_nxt = count_r;
                    nmatch_nxt = '0;
                  end else begin
                    ost_nxt = ST_MATCH;
                    oaddr_nxt = hold_r.key_addr;
                    omask_nxt = hold_r.key_mask;
                    olast_nxt = 1'b0;
                    nmatch_nxt = nmatch_r + 1'b1;
                  end
                end
              end
            end
            OP_DELETE: begin
              if ((rd_data.route_dest & rd_data.route_mask) == nkey_r) begin
                state_nxt = S_SHRD;
                sh_nxt = pos_r + 1'b1;
              end
            end
            default: begin
              if (mk == nkey_r) begin
                state_nxt = S_DONE;
                ost_nxt = ST_DUP;
                oaddr_nxt = '0;
                omask_nxt = '0;
                olast_nxt = 1'b1;
              end else if (mk > nkey_r) begin
                if (count_r >= CW'(TABLE_DEPTH)) begin
                  state_nxt = S_DONE;
                  ost_nxt = ST_TABFULL;
                  oaddr_nxt = '0;
                  omask_nxt = '0;
                  olast_nxt = 1'b1;
                end else begin
                  state_nxt = S_SHRD;
                  sh_nxt = count_r;
                end
              end
            end
          endcase
          if (state_nxt == S_EVAL) begin
            state_nxt = S_READ;
            if (!(op_r == OP_LOOKUP && mk > naddr_r)) begin
              pos_nxt = pos_r + 1'b1;
            end
          end
          if (op_r == OP_LOOKUP && mk <= naddr_r &&
              (naddr_r & rd_data.key_mask) == mk && nmatch_r < {1'b0, limit_r}) begin
            if (nmatch_r != '0) begin
              state_nxt = S_EMIT;
              ost_nxt = ST_MATCH;
              oaddr_nxt = hold_r.key_addr;
              omask_nxt = hold_r.key_mask;
              olast_nxt = 1'b0;
            end
            hold_nxt = rd_data;
            nmatch_nxt = nmatch_r + 1'b1;
          end
        end
      end
      S_SHRD: begin
        // insert shifts tail up from the end; delete pulls it down from pos+1
        if (op_r == OP_DELETE) begin
          rd_addr = sh_r[AW-1:0];
          if (sh_r >= count_r) begin
            state_nxt = S_DONE;
            count_nxt = count_r - 1'b1;
            ost_nxt = ST_OK;
            oaddr_nxt = '0;
            omask_nxt = '0;
            olast_nxt = 1'b1;
          end else begin
            state_nxt = S_SHWR;
          end
        end else begin
          rd_addr = AW'(sh_r - 1'b1);
          if (sh_r == pos_r) begin
            wr_en = 1'b1;
            wr_addr = pos_r[AW-1:0];
            count_nxt = count_r + 1'b1;
            state_nxt = S_DONE;
            ost_nxt = ST_OK;
            oaddr_nxt = '0;
            omask_nxt = '0;
            olast_nxt = 1'b1;
          end else begin
            state_nxt = S_SHWR;
          end
        end
      end
      S_SHWR: begin
        wr_en = 1'b1;
        wr_data = rd_data;
        if (op_r == OP_DELETE) begin
          wr_addr = AW'(sh_r - 1'b1);
          sh_nxt = sh_r + 1'b1;
        end else begin
          wr_addr = sh_r[AW-1:0];
          sh_nxt = sh_r - 1'b1;
        end
        state_nxt = S_SHRD;
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          if (olast_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= DefResultLimit;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_result_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    sh_r     <= sh_nxt;
    nmatch_r <= nmatch_nxt;
    hold_r   <= hold_nxt;
    ost_r    <= ost_nxt;
    oaddr_r  <= oaddr_nxt;
    omask_r  <= omask_nxt;
    olast_r  <= olast_nxt;
    if (in_acc) begin
      op_r    <= op_t'(in_operation);
      naddr_r <= in_neighbor_addr;
      unique case (op_t'(in_operation))
        OP_ADD_GW: begin
          nkey_r <= in_gateway_addr;
          new_r  <= '{in_gateway_addr, FullMask, in_route_addr, in_route_mask, 1'b1};
        end
        default: begin
          nkey_r <= in_route_addr & in_route_mask;
          new_r  <= '{in_route_addr, in_route_mask, in_route_addr, in_route_mask, 1'b0};
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("entry count beyond depth");
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && !ov_r |=> !ov_r || $past(state_r) != S_IDLE)
    else $error("result without request");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> state_r == S_IDLE) else $error("config taken while busy");
`endif

endmodule
